>>> src/kmp_pkg.sv
// Shared definitions for the streaming KMP matcher: default sizes, beat
// widths and operation codes. Depends on nothing; imported by kmp_stream_matcher.
package kmp_pkg;

    // Default configuration for the top-level parameters.
    localparam int MAX_PATTERN_DEF   = 64;
    localparam int POSITION_BITS_DEF = 32;

    // Beat widths on the stream ports.
    localparam int S_DATA_W = 8;
    localparam int S_USER_W = 2;
    localparam int M_DATA_W = 40;

    // Result field widths.
    localparam int START_W = 32;
    localparam int FVAL_W  = 6;

    // Operation codes carried in s_tuser.
    localparam logic [S_USER_W-1:0] OP_CLEAR   = 2'd0;
    localparam logic [S_USER_W-1:0] OP_APPEND  = 2'd1;
    localparam logic [S_USER_W-1:0] OP_TEXT    = 2'd2;
    localparam logic [S_USER_W-1:0] OP_RESTART = 2'd3;

endpackage

>>> src/kmp_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing; used for the pattern and failure stores.
module kmp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> src/kmp_stream_matcher.sv
// Top level of the streaming Knuth-Morris-Pratt matcher.
// Depends on kmp_pkg and kmp_ram (pattern store and failure store).

// Every input beat yields exactly one result beat. s_tuser selects the operation
// (0 clear, 1 append pattern byte, 2 text byte, 3 restart text) and s_tdata holds
// the byte. Clear, restart, an append to an empty or full pattern, and a text byte
// against an empty pattern go from idle straight to the finish state. An append or
// a text byte otherwise walks back through the failure table in the look state, and
// a text byte that completes an occurrence passes through the tail state to fetch the
// failure entry of the last pattern position. Each hop is one round trip through
// the registered read of the pattern and failure memories; hops amortize to at most
// one per byte. A result is finished only while the output register is free or being
// read; it then waits there, and the next beat is taken while it waits. Match positions
// wrap at POSITION_BITS and are cut or zero-extended to the 32-bit field.
module kmp_stream_matcher #(
    parameter int MAX_PATTERN   = kmp_pkg::MAX_PATTERN_DEF,
    parameter int POSITION_BITS = kmp_pkg::POSITION_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [kmp_pkg::S_DATA_W-1:0]  s_tdata,   // [7:0] char_in
    input  logic [kmp_pkg::S_USER_W-1:0]  s_tuser,   // [1:0] op
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [0] match, [32:1] match_start, [38:33] failure_value, [39] status
    output logic [kmp_pkg::M_DATA_W-1:0]  m_tdata
);

    import kmp_pkg::*;

    localparam int FW = $clog2(MAX_PATTERN);
    localparam int LW = $clog2(MAX_PATTERN + 1);
    localparam int PB = POSITION_BITS;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_LOOK = 2'd1;
    localparam logic [1:0] ST_TAIL = 2'd2;
    localparam logic [1:0] ST_FIN  = 2'd3;

    logic [1:0]          state_reg, state_next;
    logic [S_USER_W-1:0] op_reg, op_next;
    logic [7:0]          ch_reg, ch_next;
    logic [FW-1:0]       j_reg, j_next;
    logic [FW-1:0]       jfin_reg, jfin_next;
    logic                mfin_reg, mfin_next;
    logic [LW-1:0]       len_reg, len_next;
    logic [FW-1:0]       bp_reg, bp_next;
    logic [FW-1:0]       mc_reg, mc_next;
    logic [PB-1:0]       pos_reg, pos_next;
    logic                m_valid_reg, m_valid_next;
    logic [M_DATA_W-1:0] m_data_reg, m_data_next;

    logic [7:0]          pat_rd;
    logic [FW-1:0]       fail_rd;
    logic [FW-1:0]       pat_ra, fail_ra;
    logic                wr_en;
    logic [FW-1:0]       wr_addr;

    logic                accept, out_free, full, needs_loop;
    logic [S_USER_W-1:0] in_op;
    logic [7:0]          in_ch;
    logic [FW-1:0]       start_j;
    logic                mismatch, fall, hit;
    logic [LW-1:0]       j_new;
    logic                commit;
    logic [FW-1:0]       cj;
    logic                cm;
    logic                r_match, r_status;
    logic [PB-1:0]       r_start;
    logic [FVAL_W-1:0]   r_fval;

    // Handshake and decode of the incoming beat.
    assign s_tready   = (state_reg == ST_IDLE);
    assign accept     = s_tvalid && s_tready;
    assign in_op      = s_tuser;
    assign in_ch      = s_tdata;
    assign out_free   = !m_valid_reg || m_tready;
    assign full       = (len_reg == LW'(MAX_PATTERN));
    assign start_j    = (in_op == OP_APPEND) ? bp_reg : mc_reg;
    assign needs_loop = (len_reg != '0) &&
                        (((in_op == OP_APPEND) && !full) || (in_op == OP_TEXT));

    // Compare the fetched pattern byte; fall back while it mismatches.
    assign mismatch = (ch_reg != pat_rd);
    assign fall     = (j_reg != '0) && mismatch;
    assign j_new    = LW'(j_reg) + LW'(!mismatch);
    assign hit      = (op_reg == OP_TEXT) && (j_new >= len_reg);

    // Read addresses: the start state on accept, the failure link on a fallback,
    // the last pattern position after a full match.
    always_comb begin
        pat_ra  = start_j;
        fail_ra = start_j - FW'(1);
        if (state_reg == ST_LOOK) begin
            if (fall) begin
                pat_ra  = fail_rd;
                fail_ra = fail_rd - FW'(1);
            end else if (hit) begin
                fail_ra = FW'(len_reg - LW'(1));
            end
        end
    end

    // Sequencer, commit of the architectural state and result formation.
    always_comb begin
        state_next   = state_reg;
        op_next      = op_reg;
        ch_next      = ch_reg;
        j_next       = j_reg;
        jfin_next    = jfin_reg;
        mfin_next    = mfin_reg;
        len_next     = len_reg;
        bp_next      = bp_reg;
        mc_next      = mc_reg;
        pos_next     = pos_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        commit       = 1'b0;
        cj           = jfin_reg;
        cm           = mfin_reg;
        wr_en        = 1'b0;
        wr_addr      = FW'(len_reg);
        r_match      = 1'b0;
        r_status     = 1'b0;
        r_start      = '0;
        r_fval       = '0;

        if (m_tready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    op_next   = in_op;
                    ch_next   = in_ch;
                    j_next    = start_j;
                    jfin_next = '0;
                    mfin_next = 1'b0;
                    state_next = needs_loop ? ST_LOOK : ST_FIN;
                end
            end
            ST_LOOK: begin
                if (fall) begin
                    j_next = fail_rd;
                end else if (hit) begin
                    state_next = ST_TAIL;
                end else begin
                    cj = FW'(j_new);
                    cm = 1'b0;
                    if (out_free) begin
                        commit     = 1'b1;
                        state_next = ST_IDLE;
                    end else begin
                        jfin_next  = cj;
                        mfin_next  = 1'b0;
                        state_next = ST_FIN;
                    end
                end
            end
            ST_TAIL: begin
                cj = fail_rd;
                cm = 1'b1;
                if (out_free) begin
                    commit     = 1'b1;
                    state_next = ST_IDLE;
                end else begin
                    jfin_next  = cj;
                    mfin_next  = 1'b1;
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    commit     = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // Apply the finished operation and load the result beat.
        if (commit) begin
            case (op_reg)
                OP_CLEAR: begin
                    len_next = '0;
                    bp_next  = '0;
                    mc_next  = '0;
                    pos_next = '0;
                end
                OP_APPEND: begin
                    if (full) begin
                        r_status = 1'b1;
                    end else begin
                        wr_en    = 1'b1;
                        len_next = len_reg + LW'(1);
                        bp_next  = cj;
                        mc_next  = '0;
                        pos_next = '0;
                        r_fval   = FVAL_W'(cj);
                    end
                end
                OP_TEXT: begin
                    if (len_reg != '0) begin
                        mc_next = cj;
                        if (cm) begin
                            r_match = 1'b1;
                            r_start = pos_reg - PB'(len_reg) + PB'(1);
                        end
                    end
                    pos_next = pos_reg + PB'(1);
                end
                OP_RESTART: begin
                    mc_next  = '0;
                    pos_next = '0;
                end
                default: begin
                    mc_next = mc_reg;
                end
            endcase
            m_valid_next = 1'b1;
            m_data_next  = {r_status, r_fval, START_W'(r_start), r_match};
        end
    end

    // Control state is reset; payload registers are not.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            len_reg     <= '0;
            bp_reg      <= '0;
            mc_reg      <= '0;
            pos_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            len_reg     <= len_next;
            bp_reg      <= bp_next;
            mc_reg      <= mc_next;
            pos_reg     <= pos_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg     <= op_next;
        ch_reg     <= ch_next;
        j_reg      <= j_next;
        jfin_reg   <= jfin_next;
        mfin_reg   <= mfin_next;
        m_data_reg <= m_data_next;
    end

    // Pattern bytes and failure entries, written at the append position.
    kmp_ram #(
        .WIDTH (8),
        .DEPTH (MAX_PATTERN)
    ) u_pat_ram (
        .clk   (aclk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (ch_reg),
        .raddr (pat_ra),
        .rdata (pat_rd)
    );

    kmp_ram #(
        .WIDTH (FW),
        .DEPTH (MAX_PATTERN)
    ) u_fail_ram (
        .clk   (aclk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (cj),
        .raddr (fail_ra),
        .rdata (fail_rd)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

`ifndef SYNTHESIS
    // The text state never reaches the pattern length.
    a_matched_below_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (LW'(mc_reg) < len_reg) || (mc_reg == '0))
        else $error("matched count reached the pattern length");

    // The border under construction is shorter than the pattern.
    a_border_below_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (LW'(bp_reg) < len_reg) || ((len_reg == '0) && (bp_reg == '0)))
        else $error("build prefix not below the pattern length");

    // The pattern store never holds more than its depth.
    a_len_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        len_reg <= LW'(MAX_PATTERN))
        else $error("pattern length exceeds the store depth");

    // The fallback walk only visits written pattern positions.
    a_walk_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_LOOK) |-> (LW'(j_reg) < len_reg))
        else $error("fallback index outside the pattern");

    // A match beat carries no append result.
    a_match_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg[0]) |-> (m_data_reg[M_DATA_W-1:START_W+1] == '0))
        else $error("match beat with failure value or status set");
`endif

endmodule

>>> tb/kmp_match_checker.sv
// Scoreboard for the streaming KMP matcher: watches both stream channels, predicts
// each result beat from the accepted input beats and compares field by field.
// Depends on kmp_pkg for beat widths, field widths and operation codes.
module kmp_match_checker (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    input  logic                         s_tready,
    input  logic [kmp_pkg::S_DATA_W-1:0] s_tdata,   // [7:0] char_in
    input  logic [kmp_pkg::S_USER_W-1:0] s_tuser,   // [1:0] op
    input  logic                         m_tvalid,
    input  logic                         m_tready,
    // [0] match, [32:1] match_start, [38:33] failure_value, [39] status
    input  logic [kmp_pkg::M_DATA_W-1:0] m_tdata,
    output int                           fail_count,
    output int                           results_due
);

    import kmp_pkg::*;

    // Result beat layout, highest field first so that it overlays m_tdata.
    typedef struct packed {
        logic               status;
        logic [FVAL_W-1:0]  failure_value;
        logic [START_W-1:0] match_start;
        logic               match;
    } kmp_result_t;

    localparam int PAT_DEPTH = MAX_PATTERN_DEF;

    // Shadow copy of the matcher state.
    logic [7:0]  pattern_bytes [PAT_DEPTH];
    int          border_table [PAT_DEPTH];
    int          pattern_len  = 0;
    int          build_border = 0;
    int          text_matched = 0;
    logic [31:0] text_pos     = '0;

    kmp_result_t result_fifo [$];
    int          mismatches   = 0;

    // Applies one input beat to the shadow state and returns the result it yields.
    function automatic kmp_result_t advance_matcher(input logic [1:0] op,
                                                    input logic [7:0] ch);
        kmp_result_t r;
        int j;
        r = '0;
        j = 0;
        case (op)
            OP_CLEAR: begin
                pattern_len  = 0;
                build_border = 0;
                text_matched = 0;
                text_pos     = '0;
            end
            OP_APPEND: begin
                if (pattern_len >= PAT_DEPTH) begin
                    // Store full: the byte is dropped and nothing else moves.
                    r.status = 1'b1;
                end else begin
                    pattern_bytes[pattern_len] = ch;
                    // Extend the current border, falling back on a mismatch.
                    if (pattern_len > 0) begin
                        j = build_border;
                        while (j > 0 && ch != pattern_bytes[j])
                            j = border_table[j-1];
                        if (ch == pattern_bytes[j])
                            j++;
                    end
                    border_table[pattern_len] = j;
                    build_border    = j;
                    pattern_len     = pattern_len + 1;
                    text_matched    = 0;
                    text_pos        = '0;
                    r.failure_value = j[FVAL_W-1:0];
                end
            end
            OP_TEXT: begin
                // An empty pattern never matches, but the position still moves.
                if (pattern_len > 0) begin
                    j = text_matched;
                    while (j > 0 && ch != pattern_bytes[j])
                        j = border_table[j-1];
                    if (ch == pattern_bytes[j])
                        j++;
                    if (j >= pattern_len) begin
                        r.match       = 1'b1;
                        r.match_start = text_pos - 32'(pattern_len) + 32'd1;
                        j = border_table[pattern_len-1];
                    end
                    text_matched = j;
                end
                text_pos = text_pos + 32'd1;
            end
            default: begin
                text_matched = 0;
                text_pos     = '0;
            end
        endcase
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    // Result beats are checked before the input beat of the same edge is predicted;
    // the block cannot answer a beat on the edge that accepts it.
    always @(posedge aclk) begin : watch_channels
        kmp_result_t got_beat;
        kmp_result_t want_beat;
        if (!aresetn) begin
            pattern_len  = 0;
            build_border = 0;
            text_matched = 0;
            text_pos     = '0;
            result_fifo.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got_beat = m_tdata;
                if (result_fifo.size() == 0) begin
                    $display("%0t: result beat 0x%0h with none expected", $time, m_tdata);
                    mismatches++;
                end else begin
                    want_beat = result_fifo.pop_front();
                    check_field("match", 32'(want_beat.match), 32'(got_beat.match));
                    check_field("match_start", want_beat.match_start,
                                got_beat.match_start);
                    check_field("failure_value", 32'(want_beat.failure_value),
                                32'(got_beat.failure_value));
                    check_field("status", 32'(want_beat.status), 32'(got_beat.status));
                end
            end
            if (s_tvalid && s_tready)
                result_fifo.insert(result_fifo.size(), advance_matcher(s_tuser, s_tdata));
        end
        fail_count  <= mismatches;
        results_due <= result_fifo.size();
    end

endmodule

>>> tb/tb_kmp_stream_matcher.sv
// Top of the KMP matcher testbench: clock, reset, stimulus with bursty input and a
// stalling receiver, and the verdict. Depends on kmp_pkg, kmp_stream_matcher and
// kmp_match_checker.
module tb_kmp_stream_matcher;
    import kmp_pkg::*;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int RANDOM_ITEMS = 1800;
    localparam int DRAIN_CYCLES = 100;

    logic                aclk = 1'b0;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;   // [7:0] char_in
    logic [S_USER_W-1:0] s_tuser;   // [1:0] op
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    // [0] match, [32:1] match_start, [38:33] failure_value, [39] status
    logic [M_DATA_W-1:0] m_tdata;

    int fail_count;
    int results_due;
    int cycle_count = 0;
    int burst_left  = 0;
    int rx_left     = 0;
    int rx_mode     = 0;
    int items_sent  = 0;

    // Pattern as the sender believes it stands, used to build matching text.
    logic [7:0] pattern_copy [$];
    logic [7:0] alphabet [3];

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    kmp_stream_matcher dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    kmp_match_checker scoreboard (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .fail_count  (fail_count),
        .results_due (results_due)
    );

    // Hard stop in case the block hangs.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_kmp_stream_matcher NOT OK");
            $finish;
        end
    end

    // Receiver alternates between always ready, coin-flip ready and mostly stalled.
    always @(posedge aclk) begin
        if (rx_left == 0) begin
            rx_mode = $urandom_range(0, 2);
            rx_left = $urandom_range(20, 200);
        end else begin
            rx_left--;
        end
        case (rx_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= 1'($urandom_range(0, 1));
            default: m_tready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // Sends one beat, opening a gap first when the current burst is used up.
    task automatic send_beat(input logic [1:0] op, input logic [7:0] ch);
        int gap;
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            gap = $urandom_range(1, 8);
            repeat (gap) @(posedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 30);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= ch;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        burst_left--;
        items_sent++;
        if (op == OP_CLEAR)
            pattern_copy.delete();
        else if (op == OP_APPEND && pattern_copy.size() < MAX_PATTERN_DEF)
            pattern_copy.insert(pattern_copy.size(), ch);
    endtask

    initial begin
        int k;
        int r;
        int plen;
        int tlen;
        int alpha_n;
        bit copy_mode;

        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= OP_CLEAR;
        aresetn  <= 1'b0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Text against an empty pattern: no match, position still advances.
        send_beat(OP_TEXT, 8'h00);
        send_beat(OP_TEXT, 8'hFF);
        // One-byte pattern; consecutive matches overlap.
        send_beat(OP_APPEND, 8'hFF);
        send_beat(OP_TEXT, 8'hFF);
        send_beat(OP_TEXT, 8'hFF);
        // Pattern FF 00 FF has a border of one; text finds overlapping hits.
        send_beat(OP_APPEND, 8'h00);
        send_beat(OP_APPEND, 8'hFF);
        send_beat(OP_TEXT, 8'hFF);
        send_beat(OP_TEXT, 8'h00);
        send_beat(OP_TEXT, 8'hFF);
        send_beat(OP_TEXT, 8'h00);
        send_beat(OP_TEXT, 8'hFF);
        // Restart drops partial matches and rewinds the position.
        send_beat(OP_RESTART, 8'hA5);
        send_beat(OP_TEXT, 8'h00);
        send_beat(OP_TEXT, 8'hFF);
        send_beat(OP_TEXT, 8'h00);
        send_beat(OP_TEXT, 8'hFF);
        // Clear empties the pattern again.
        send_beat(OP_CLEAR, 8'h5A);
        send_beat(OP_TEXT, 8'h55);
        // Growing border that collapses on the last byte.
        send_beat(OP_APPEND, 8'hAA);
        send_beat(OP_APPEND, 8'hAA);
        send_beat(OP_APPEND, 8'hAA);
        send_beat(OP_APPEND, 8'h55);
        send_beat(OP_TEXT, 8'hAA);
        send_beat(OP_TEXT, 8'hAA);
        send_beat(OP_TEXT, 8'hAA);
        send_beat(OP_TEXT, 8'h55);

        // Fill the pattern store, overflow it, then match the full-length pattern.
        send_beat(OP_CLEAR, 8'h00);
        for (k = 0; k < MAX_PATTERN_DEF; k++)
            send_beat(OP_APPEND, (k % 8 == 7) ? 8'h62 : 8'h61);
        send_beat(OP_APPEND, 8'hFF);
        send_beat(OP_APPEND, 8'h00);
        for (k = 0; k < 3 * MAX_PATTERN_DEF; k++) begin
            if (k == 100)
                send_beat(OP_RESTART, 8'h00);
            send_beat(OP_TEXT, pattern_copy[k % MAX_PATTERN_DEF]);
        end

        // Random sessions: mostly a pattern from a small alphabet followed by text
        // that is likely to match, with some noise beats in between.
        while (items_sent < RANDOM_ITEMS) begin
            if ($urandom_range(0, 4) == 0) begin
                repeat ($urandom_range(1, 6))
                    send_beat(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
            end else begin
                alpha_n = $urandom_range(2, 3);
                for (k = 0; k < 3; k++)
                    alphabet[k] = 8'($urandom_range(0, 255));
                if ($urandom_range(0, 9) < 7)
                    send_beat(OP_CLEAR, 8'($urandom));
                plen = ($urandom_range(0, 99) < 6) ? $urandom_range(56, 70)
                                                   : $urandom_range(1, 6);
                repeat (plen)
                    send_beat(OP_APPEND, alphabet[$urandom_range(0, alpha_n - 1)]);
                copy_mode = 1'($urandom_range(0, 1));
                tlen = $urandom_range(8, 40) + (copy_mode ? 2 * pattern_copy.size() : 0);
                for (k = 0; k < tlen; k++) begin
                    r = $urandom_range(0, 99);
                    if (r < 3)
                        send_beat(OP_RESTART, 8'($urandom));
                    else if (r < 10)
                        send_beat(OP_TEXT, 8'($urandom_range(0, 255)));
                    else if (copy_mode && pattern_copy.size() > 0)
                        send_beat(OP_TEXT, pattern_copy[k % pattern_copy.size()]);
                    else
                        send_beat(OP_TEXT, alphabet[$urandom_range(0, alpha_n - 1)]);
                end
            end
        end

        // Drain: let the scoreboard catch up, then watch for stray beats.
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (results_due != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0)
            $display("tb_kmp_stream_matcher OK");
        else
            $display("tb_kmp_stream_matcher NOT OK");
        $finish;
    end

endmodule
